FILE: hdl/rlw_pkg.sv
// ----------------------------------------------------------------------------
// rlw_pkg
// Shared types and constants for the run-length time table walker.
// ----------------------------------------------------------------------------
package rlw_pkg;

	localparam int DATA_W = 32;
	localparam int DUR_W  = 63;
	localparam int PROD_W = 2 * DATA_W;

	localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

	typedef enum logic [1:0] {
		FUNC_CLEAR   = 2'd0,
		FUNC_APPEND  = 2'd1,
		FUNC_ADVANCE = 2'd2,
		FUNC_QUERY   = 2'd3
	} rlw_func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} rlw_state_t;

	// control from the sequencer to the duration pipeline
	typedef struct packed {
		logic start;
		logic issue;
	} rlw_walk_ctl_t;

endpackage

FILE: hdl/rlw_ram.sv
// ----------------------------------------------------------------------------
// rlw_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/rlw_dur_pipe.sv
// ----------------------------------------------------------------------------
// rlw_dur_pipe
// Duration pipeline: takes one run per cycle from the table memories, clips it
// to the query range, multiplies and accumulates with saturation.
// ----------------------------------------------------------------------------
module rlw_dur_pipe
	import rlw_pkg::*;
#(
	parameter int POS_W = 41
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rlw_walk_ctl_t       ctl,
	input  logic [DATA_W-1:0]   first_pos,
	input  logic [DATA_W-1:0]   last_pos,
	input  logic [DATA_W-1:0]   rd_count,
	input  logic [DATA_W-1:0]   rd_delta,
	output logic                busy,
	output logic [DUR_W-1:0]    sum
);

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [POS_W-1:0]    prev_q;
	logic [POS_W-1:0]    cur_pos;
	logic [POS_W-1:0]    lo_pos, hi_pos;
	logic [POS_W-1:0]    first_ext, last_ext;
	logic [POS_W-1:0]    lo_s2, hi_s2;
	logic [POS_W-1:0]    span;
	logic [DATA_W-1:0]   delta_s2, delta_s3;
	logic [DATA_W-1:0]   n_s3;
	logic [PROD_W-1:0]   prod_s4;
	logic [DUR_W+1:0]    acc;
	logic [DUR_W-1:0]    sum_q;

	assign first_ext = POS_W'(first_pos);
	assign last_ext  = POS_W'(last_pos);

	// s1: position of the run end and its clipped sample window
	assign cur_pos = prev_q + POS_W'(rd_count);
	assign lo_pos  = (first_ext > prev_q + POS_W'(1)) ? first_ext : prev_q + POS_W'(1);
	assign hi_pos  = (last_ext < cur_pos) ? last_ext : cur_pos;

	// window never exceeds the run count when non-empty
	assign span = hi_s2 - lo_s2 + POS_W'(1);

	assign acc = (DUR_W+2)'(sum_q) + (DUR_W+2)'(prod_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			prev_q <= '0;
		end else if (v_s1) begin
			prev_q <= cur_pos;
		end
		lo_s2    <= lo_pos;
		hi_s2    <= hi_pos;
		delta_s2 <= rd_delta;
		n_s3     <= (hi_s2 >= lo_s2) ? span[DATA_W-1:0] : '0;
		delta_s3 <= delta_s2;
		prod_s4  <= PROD_W'(n_s3) * PROD_W'(delta_s3);
		if (ctl.start) begin
			sum_q <= '0;
		end else if (v_s4) begin
			sum_q <= (acc > (DUR_W+2)'(DUR_MAX)) ? DUR_MAX : acc[DUR_W-1:0];
		end
	end

	assign busy = v_s1 | v_s2 | v_s3 | v_s4;
	assign sum  = sum_q;

endmodule

FILE: hdl/run_length_time_table_walker.sv
// Run-length time table walker: keeps up to MAX_RUNS runs of (sample count,
// per-sample duration) in two table RAMs and a sample cursor in registers.
// Every transaction yields exactly one result. Clear, append and an advance
// that stays inside its run go straight to the result state; an advance that
// steps into another loaded run passes through a fetch state first, since the
// next run's count is fetched from the count RAM. A duration query reads the
// loaded runs from the RAMs one per cycle and feeds a four-stage clip,
// multiply and saturating-add pipeline, and its result is taken once the
// pipeline has drained (an empty table goes straight to the drain). A new input
// transaction is taken once the previous result has been passed to the output
// register, even while that result is still stalled there.
// ----------------------------------------------------------------------------
// run_length_time_table_walker
// Top level: sequencer, cursor and table bookkeeping, table RAMs and output.
// ----------------------------------------------------------------------------
module run_length_time_table_walker
	import rlw_pkg::*;
#(
	parameter int MAX_RUNS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [DATA_W-1:0] run_count,
	input  logic [DATA_W-1:0] run_delta,
	input  logic [DATA_W-1:0] first_sample,
	input  logic [DATA_W-1:0] last_sample,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic              cursor_valid,
	output logic [DUR_W-1:0]  range_duration,
	output logic [DATA_W-1:0] total_samples
);

	localparam int AW    = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int CW    = $clog2(MAX_RUNS + 1);
	localparam int POS_W = DATA_W + CW;
	localparam logic [CW-1:0] RUNS_MAX = CW'(MAX_RUNS);

	rlw_state_t        state_q, state_d;
	rlw_func_t         op;
	rlw_walk_ctl_t     walk_ctl;

	logic              in_acc;
	logic              slot_free;
	logic              out_load;
	logic [CW-1:0]     runs_loaded_q;
	logic [CW-1:0]     cursor_run_q;
	logic [DATA_W-1:0] cursor_sample_q;
	logic [DATA_W-1:0] sample_total_q;
	logic [DATA_W-1:0] cur_count_q;
	logic [CW-1:0]     rd_cnt_q;
	logic [DATA_W-1:0] first_q, last_q;
	logic              res_ok_q;
	logic              res_query_q;

	logic              table_full;
	logic              adv_live, adv_cross, adv_fetch;
	logic [DATA_W-1:0] nxt_sample;
	logic [CW-1:0]     nxt_run;
	logic              ram_we;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_count, ram_delta;
	logic              pipe_busy;
	logic [DUR_W-1:0]  pipe_sum;
	logic              cur_valid;

	logic              out_valid_q, ok_q, cursor_valid_q;
	logic [DUR_W-1:0]  dur_q;
	logic [DATA_W-1:0] total_q;

	assign op         = rlw_func_t'(func);
	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign slot_free  = !out_valid_q || !out_stall;
	assign out_load   = (state_q == ST_DONE) && slot_free;

	assign table_full = (runs_loaded_q >= RUNS_MAX);
	assign adv_live   = (cursor_run_q < runs_loaded_q);
	assign nxt_sample = cursor_sample_q + DATA_W'(1);
	assign adv_cross  = (nxt_sample >= cur_count_q);
	assign nxt_run    = cursor_run_q + CW'(1);
	assign adv_fetch  = adv_live && adv_cross && (nxt_run < runs_loaded_q);
	assign cur_valid  = adv_live && (cursor_sample_q < cur_count_q);

	assign ram_we     = in_acc && (op == FUNC_APPEND) && !table_full;

	// sequencer: next state and datapath controls
	always_comb begin
		state_d        = state_q;
		ram_raddr      = '0;
		walk_ctl.start = 1'b0;
		walk_ctl.issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op)
						FUNC_QUERY: begin
							walk_ctl.start = 1'b1;
							state_d = (runs_loaded_q == '0) ? ST_DRAIN : ST_WALK;
						end
						FUNC_ADVANCE: begin
							if (adv_fetch) begin
								ram_raddr = nxt_run[AW-1:0];
								state_d   = ST_FETCH;
							end else begin
								state_d = ST_DONE;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_FETCH: begin
				state_d = ST_DONE;
			end
			ST_WALK: begin
				ram_raddr      = rd_cnt_q[AW-1:0];
				walk_ctl.issue = 1'b1;
				if (rd_cnt_q + CW'(1) == runs_loaded_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table bookkeeping and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_loaded_q   <= '0;
			cursor_run_q    <= '0;
			cursor_sample_q <= '0;
			sample_total_q  <= '0;
			rd_cnt_q        <= '0;
			res_ok_q        <= 1'b0;
			res_query_q     <= 1'b0;
		end else begin
			if (in_acc) begin
				res_query_q <= (op == FUNC_QUERY);
				case (op)
					FUNC_CLEAR: begin
						runs_loaded_q   <= '0;
						cursor_run_q    <= '0;
						cursor_sample_q <= '0;
						sample_total_q  <= '0;
						res_ok_q        <= 1'b1;
					end
					FUNC_APPEND: begin
						if (!table_full) begin
							runs_loaded_q  <= runs_loaded_q + CW'(1);
							sample_total_q <= sample_total_q + run_count;
							res_ok_q       <= 1'b1;
						end else begin
							res_ok_q <= 1'b0;
						end
					end
					FUNC_ADVANCE: begin
						if (!adv_live) begin
							res_ok_q <= 1'b0;
						end else if (adv_cross) begin
							cursor_run_q    <= nxt_run;
							cursor_sample_q <= '0;
							res_ok_q        <= (nxt_run < runs_loaded_q);
						end else begin
							cursor_sample_q <= nxt_sample;
							res_ok_q        <= 1'b1;
						end
					end
					FUNC_QUERY: begin
						rd_cnt_q <= '0;
						res_ok_q <= 1'b1;
					end
					default: begin
						res_ok_q <= 1'b1;
					end
				endcase
			end else if (state_q == ST_WALK) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
		end
	end

	// count of the cursor's run, kept beside the RAM, and the query range
	always_ff @(posedge clk) begin
		if (ram_we && (cursor_run_q == runs_loaded_q)) begin
			cur_count_q <= run_count;
		end else if (state_q == ST_FETCH) begin
			cur_count_q <= ram_count;
		end
		if (in_acc && (op == FUNC_QUERY)) begin
			first_q <= (first_sample == '0) ? DATA_W'(1) : first_sample;
			last_q  <= last_sample;
		end
	end

	rlw_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_RUNS)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (runs_loaded_q[AW-1:0]),
		.wdata (run_count),
		.raddr (ram_raddr),
		.rdata (ram_count)
	);

	rlw_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_RUNS)
	) u_delta_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (runs_loaded_q[AW-1:0]),
		.wdata (run_delta),
		.raddr (ram_raddr),
		.rdata (ram_delta)
	);

	rlw_dur_pipe #(
		.POS_W (POS_W)
	) u_dur_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (walk_ctl),
		.first_pos (first_q),
		.last_pos  (last_q),
		.rd_count  (ram_count),
		.rd_delta  (ram_delta),
		.busy      (pipe_busy),
		.sum       (pipe_sum)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ok_q           <= res_ok_q;
			cursor_valid_q <= cur_valid;
			dur_q          <= res_query_q ? pipe_sum : '0;
			total_q        <= sample_total_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign cursor_valid   = cursor_valid_q;
	assign range_duration = dur_q;
	assign total_samples  = total_q;

`ifndef SYNTHESIS
	a_runs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		runs_loaded_q <= RUNS_MAX)
		else $error("loaded run count beyond table size");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_run_q <= runs_loaded_q)
		else $error("cursor run beyond loaded runs");

	a_full_append: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (op == FUNC_APPEND) && table_full) |=> !res_ok_q)
		else $error("append to full table reported ok");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished transaction not presented at output");

	a_walk_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pipe_busy)
		else $error("duration pipeline busy while sequencer idle");
`endif

endmodule

FILE: tb/sv/run_length_time_table_walker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_time_table_walker_test
// Self-checking testbench for the run-length time table walker. A directed
// table covers the edge cases, then random segments of clears, appends,
// advances and duration queries run under bursty input and output stalls.
// Each result is checked against a local table and cursor model or the typed row's want.
// ----------------------------------------------------------------------------
module run_length_time_table_walker_test;
	import rlw_pkg::*;

	localparam int MAX_RUNS    = 256;
	localparam int ITEM_TARGET = 950;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 300;

	typedef struct packed {
		logic              ok;
		logic              cursor_valid;
		logic [DUR_W-1:0]  range_duration;
		logic [DATA_W-1:0] total_samples;
	} result_t;

	typedef struct packed {
		rlw_func_t         func;
		logic [DATA_W-1:0] count;
		logic [DATA_W-1:0] delta;
		logic [DATA_W-1:0] first;
		logic [DATA_W-1:0] last;
		logic              typed;
		result_t           want;
	} item_t;

	localparam result_t NO_RES = '0;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        func;
	logic [DATA_W-1:0] run_count;
	logic [DATA_W-1:0] run_delta;
	logic [DATA_W-1:0] first_sample;
	logic [DATA_W-1:0] last_sample;
	logic              out_valid;
	logic              out_stall;
	logic              ok;
	logic              cursor_valid;
	logic [DUR_W-1:0]  range_duration;
	logic [DATA_W-1:0] total_samples;

	run_length_time_table_walker #(
		.MAX_RUNS(MAX_RUNS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.run_count     (run_count),
		.run_delta     (run_delta),
		.first_sample  (first_sample),
		.last_sample   (last_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.cursor_valid  (cursor_valid),
		.range_duration(range_duration),
		.total_samples (total_samples)
	);

	// local copy of the table and cursor
	logic [DATA_W-1:0] tbl_count [MAX_RUNS];
	logic [DATA_W-1:0] tbl_delta [MAX_RUNS];
	logic [8:0]        loaded_runs;
	logic [8:0]        cur_run;
	logic [DATA_W-1:0] cur_sample;
	logic [DATA_W-1:0] running_total;

	result_t results_due [$];
	item_t   cur_item;
	result_t got;
	result_t due;

	int errors;
	int checked;
	int sent;
	int burst_left;
	int n_clear, n_append, n_rejected, n_advance, n_query, n_saturated;
	int holds_done;
	bit hold_req;
	logic [63:0] gen_span;

	// directed stimulus; typed rows carry their expected result
	item_t dir_tab [23] = '{
		'{FUNC_ADVANCE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{1'b0, 1'b0, 63'd0, 32'd0}},
		'{FUNC_QUERY, 32'd0, 32'd0, 32'd1, 32'd10, 1'b1, '{1'b1, 1'b0, 63'd0, 32'd0}},
		'{FUNC_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1,
			'{1'b1, 1'b1, 63'd0, 32'hFFFF_FFFF}},
		// total wraps back to zero
		'{FUNC_APPEND, 32'd1, 32'd0, 32'd0, 32'd0, 1'b1, '{1'b1, 1'b1, 63'd0, 32'd0}},
		'{FUNC_QUERY, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1,
			'{1'b1, 1'b1, DUR_MAX, 32'd0}},
		'{FUNC_QUERY, 32'd0, 32'd0, 32'd5, 32'd4, 1'b1, '{1'b1, 1'b1, 63'd0, 32'd0}},
		'{FUNC_QUERY, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{1'b1, 1'b1, 63'h0000_0000_FFFF_FFFF, 32'd0}},
		// first of zero becomes one, so the range is reversed
		'{FUNC_QUERY, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{1'b1, 1'b1, 63'd0, 32'd0}},
		'{FUNC_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{1'b1, 1'b0, 63'd0, 32'd0}},
		'{FUNC_APPEND, 32'd0, 32'd7, 32'd0, 32'd0, 1'b0, NO_RES},
		'{FUNC_APPEND, 32'd2, 32'd3, 32'd0, 32'd0, 1'b0, NO_RES},
		'{FUNC_ADVANCE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, NO_RES},
		'{FUNC_ADVANCE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, NO_RES},
		'{FUNC_ADVANCE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, NO_RES},
		'{FUNC_ADVANCE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, NO_RES},
		'{FUNC_APPEND, 32'd3, 32'd5, 32'd0, 32'd0, 1'b0, NO_RES},
		'{FUNC_ADVANCE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, NO_RES},
		'{FUNC_QUERY, 32'd0, 32'd0, 32'd1, 32'd100, 1'b0, NO_RES},
		'{FUNC_QUERY, 32'd0, 32'd0, 32'd2, 32'd4, 1'b0, NO_RES},
		'{FUNC_QUERY, 32'd0, 32'd0, 32'd0, 32'd2, 1'b0, NO_RES},
		'{FUNC_APPEND, 32'hAAAA_AAAA, 32'h5555_5555, 32'd0, 32'd0, 1'b0, NO_RES},
		'{FUNC_QUERY, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, NO_RES},
		'{FUNC_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{1'b1, 1'b0, 63'd0, 32'd0}}
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [DUR_W-1:0] span_duration(input logic [63:0] first_in,
		input logic [63:0] last_in);
		logic [63:0] sum, base, top, lo, hi, prod, first, last;
		bit done;
		first = (first_in == 64'd0) ? 64'd1 : first_in;
		last  = last_in;
		sum   = 64'd0;
		base  = 64'd0;
		done  = 1'b0;
		if (first > last)
			return '0;
		for (int r = 0; r < loaded_runs; r++) begin
			if (!done) begin
				top = base + {32'd0, tbl_count[r]};
				if (top >= first) begin
					lo = (first > base + 64'd1) ? first : base + 64'd1;
					hi = (last < top) ? last : top;
					if (hi + 64'd1 > lo) begin
						prod = (hi - lo + 64'd1) * {32'd0, tbl_delta[r]};
						if (prod > {1'b0, DUR_MAX} - sum)
							sum = {1'b0, DUR_MAX};
						else
							sum = sum + prod;
					end
					if (top >= last)
						done = 1'b1;
				end
				base = top;
			end
		end
		return sum[DUR_W-1:0];
	endfunction

	function automatic result_t table_op_result(input item_t it);
		result_t r;
		logic [DATA_W-1:0] nxt;
		r = NO_RES;
		r.ok = 1'b1;
		case (it.func)
			FUNC_CLEAR: begin
				loaded_runs   = '0;
				cur_run       = '0;
				cur_sample    = '0;
				running_total = '0;
			end
			FUNC_APPEND: begin
				if (loaded_runs < MAX_RUNS) begin
					tbl_count[loaded_runs] = it.count;
					tbl_delta[loaded_runs] = it.delta;
					loaded_runs   = loaded_runs + 9'd1;
					running_total = running_total + it.count;
				end else begin
					r.ok = 1'b0;
				end
			end
			FUNC_ADVANCE: begin
				if (cur_run >= loaded_runs) begin
					r.ok = 1'b0;
				end else begin
					nxt = cur_sample + 32'd1;
					if (nxt >= tbl_count[cur_run]) begin
						cur_run    = cur_run + 9'd1;
						cur_sample = '0;
						if (cur_run >= loaded_runs)
							r.ok = 1'b0;
					end else begin
						cur_sample = nxt;
					end
				end
			end
			FUNC_QUERY: begin
				r.range_duration = span_duration({32'd0, it.first}, {32'd0, it.last});
			end
		endcase
		if (cur_run < loaded_runs)
			r.cursor_valid = (cur_sample < tbl_count[cur_run]);
		r.total_samples = running_total;
		return r;
	endfunction

	function automatic item_t rand_item(input rlw_func_t f, input logic [63:0] span);
		item_t it;
		logic [DATA_W-1:0] b, a, c;
		int pick;
		it       = '0;
		it.func  = f;
		it.count = $urandom;
		it.delta = $urandom;
		it.first = $urandom;
		it.last  = $urandom;
		it.want  = NO_RES;
		pick = $urandom_range(0, 9);
		if (f == FUNC_APPEND) begin
			if (pick < 6)
				it.count = $urandom_range(0, 4);
			else if (pick < 8)
				it.count = $urandom_range(0, 300);
			if ($urandom_range(0, 3) == 0)
				it.delta = $urandom_range(0, 10);
		end
		// most queries land inside or just past the loaded samples
		if (f == FUNC_QUERY && pick < 8) begin
			b = (span > 64'hFFFF_FFF0) ? 32'hFFFF_FFF0 : span[31:0];
			a = $urandom_range(0, b + 2);
			c = $urandom_range(0, b + 2);
			if (pick < 6 && a > c) begin
				it.first = c;
				it.last  = a;
			end else begin
				it.first = a;
				it.last  = c;
			end
		end
		return it;
	endfunction

	function automatic rlw_func_t rand_func();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return FUNC_CLEAR;
		else if (r < 3)
			return FUNC_APPEND;
		else if (r < 12)
			return FUNC_ADVANCE;
		return FUNC_QUERY;
	endfunction

	// called at a falling edge, returns at a falling edge after acceptance
	task automatic offer(input item_t it);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		cur_item     = it;
		func         = it.func;
		run_count    = it.count;
		run_delta    = it.delta;
		first_sample = it.first;
		last_sample  = it.last;
		in_valid     = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		burst_left--;
		sent++;
		if (it.func == FUNC_CLEAR)
			gen_span = 64'd0;
		else if (it.func == FUNC_APPEND)
			gen_span = gen_span + {32'd0, it.count};
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic report(input string what, input result_t e, input result_t a);
		errors++;
		if (errors <= 10)
			$display("%s: exp ok=%0b cv=%0b dur=%0h total=%0h / got ok=%0b cv=%0b dur=%0h total=%0h",
				what, e.ok, e.cursor_valid, e.range_duration, e.total_samples,
				a.ok, a.cursor_valid, a.range_duration, a.total_samples);
	endtask

	// input acceptance feeds the model, output acceptance is checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				due = table_op_result(cur_item);
				case (cur_item.func)
					FUNC_CLEAR:   n_clear++;
					FUNC_APPEND:  begin
						n_append++;
						if (!due.ok)
							n_rejected++;
					end
					FUNC_ADVANCE: n_advance++;
					FUNC_QUERY:   begin
						n_query++;
						if (due.range_duration == DUR_MAX)
							n_saturated++;
					end
				endcase
				if (cur_item.typed)
					due = cur_item.want;
				results_due.push_back(due);
			end
			if (out_valid && !out_stall) begin
				got = '{ok, cursor_valid, range_duration, total_samples};
				if (results_due.size() == 0) begin
					report("unexpected result", NO_RES, got);
				end else begin
					due = results_due.pop_front();
					checked++;
					if (got !== due)
						report("mismatch", due, got);
				end
			end
		end
	end

	// output side: stall pattern that changes mode, plus requested long hold-offs
	initial begin
		int mode;
		int cyc;
		mode = 0;
		cyc  = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_req) begin
				hold_req  = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				2: out_stall = ((cyc % 5) < 2);
				default: out_stall = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int seg, n;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		func         = FUNC_CLEAR;
		run_count    = '0;
		run_delta    = '0;
		first_sample = '0;
		last_sample  = '0;
		cur_item     = '0;
		hold_req     = 1'b0;
		errors       = 0;
		checked      = 0;
		sent         = 0;
		burst_left   = 0;
		gen_span     = 64'd0;
		n_clear = 0; n_append = 0; n_rejected = 0;
		n_advance = 0; n_query = 0; n_saturated = 0;
		holds_done = 0;
		for (int i = 0; i < MAX_RUNS; i++) begin
			tbl_count[i] = '0;
			tbl_delta[i] = '0;
		end
		loaded_runs   = '0;
		cur_run       = '0;
		cur_sample    = '0;
		running_total = '0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int k = 0; k < $size(dir_tab); k++)
			offer(dir_tab[k]);
		drain();

		seg = 0;
		while (sent < ITEM_TARGET) begin
			if (seg == 6) begin
				// fill the table, push past full, then walk all of it
				offer(rand_item(FUNC_CLEAR, gen_span));
				for (int k = 0; k < MAX_RUNS + 3; k++) begin
					item_t a;
					a = rand_item(FUNC_APPEND, gen_span);
					a.count = $urandom_range(0, 3);
					offer(a);
				end
				offer('{FUNC_QUERY, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, NO_RES});
				for (int k = 0; k < 4; k++)
					offer(rand_item(FUNC_QUERY, gen_span));
				for (int k = 0; k < 10; k++)
					offer(rand_item(FUNC_ADVANCE, gen_span));
				drain();
			end else begin
				if ($urandom_range(0, 7) != 0)
					offer(rand_item(FUNC_CLEAR, gen_span));
				n = $urandom_range(1, 12);
				for (int k = 0; k < n; k++)
					offer(rand_item(FUNC_APPEND, gen_span));
				// sender keeps offering while the output is held off
				if (seg == 3 || seg == 20)
					hold_req = 1'b1;
				n = $urandom_range(4, 24);
				for (int k = 0; k < n; k++) begin
					item_t it;
					it = rand_item(rand_func(), gen_span);
					// a little pure noise on the count and the range fields
					if ($urandom_range(0, 19) == 0) begin
						it.count = $urandom;
						it.first = $urandom;
						it.last  = $urandom;
					end
					offer(it);
				end
				if (seg % 5 == 4)
					drain();
			end
			seg++;
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("ran %0d transactions, %0d results checked, %0d long output hold-offs",
			sent, checked, holds_done);
		$display("clears %0d, appends %0d (%0d on full table), advances %0d, queries %0d (%0d saturated)",
			n_clear, n_append, n_rejected, n_advance, n_query, n_saturated);
		if (errors == 0 && results_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("errors: %0d", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
